// ----- rtl/polygon_scanline_span_fill_unit_macros.svh -----
// Assertion macros shared by the span fill checker.
`ifndef POLYGON_SCANLINE_SPAN_FILL_UNIT_MACROS_SVH
`define POLYGON_SCANLINE_SPAN_FILL_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSF_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSF_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/psf_pkg.sv -----
// Package with constants and codes for the polygon scanline span fill unit.
`timescale 1ns / 1ps
`default_nettype none

package psf_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_BITS_DEF   = 13;
    localparam int MAX_RESULTS      = 8;
    localparam int WIDTH_LIMIT      = 4096;

    localparam int IN_COORD_W = 13;
    localparam int INDEX_W    = 4;
    localparam int SCAN_Y_W   = 12;
    localparam int SPAN_W     = 12;
    localparam int WIDTH_W    = 13;
    localparam int VCOUNT_W   = 5;

    localparam int S_TDATA_W   = 48;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 24;
    localparam int M_TUSER_W   = 1;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 13;

    localparam logic [WIDTH_W-1:0]  SCAN_WIDTH_RESET   = 13'd200;
    localparam logic [VCOUNT_W-1:0] VERTEX_COUNT_RESET = 5'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_SCAN_WIDTH   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_COUNT = 4'd1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/polygon_scanline_span_fill_unit.sv -----
// Even-odd scanline span generator with a shared multiplier and a serial divider.
//
//  Channel  Dir  Handshake            Contents
//  s_       in   s_tvalid/s_tready    vertex load or scanline query
//  m_       out  m_tvalid/m_tready    spans of a query (or a no-span marker), m_tlast on the final one
//  cfg_     in   cfg_valid/cfg_ready  register index and write data
//
// A load is written into the vertex store while the sequencer stays idle. A query walks
// the edges, divides once per crossing and then pairs the sorted crossings; NUM_W =
// 2*max(COORD_BITS,13)+5 is the step count of the restoring divider (31 at the default).
// s_tready is high only while the sequencer is idle; results sit in an output
// register, and the pairing step stalls while that register is still full.
// aresetn is synchronous; the vertex store has no reset.
`timescale 1ns / 1ps
`default_nettype none

module polygon_scanline_span_fill_unit #(
    parameter int MAX_VERTICES = psf_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = psf_pkg::COORD_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // vertex_index[3:0], vertex_x[16:4], vertex_y[29:17], scan_y[41:30]
    input  wire logic [psf_pkg::S_TDATA_W-1:0]    s_tdata,
    // kind[0]
    input  wire logic [psf_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // span_start[11:0], span_end[23:12]
    output logic [psf_pkg::M_TDATA_W-1:0]         m_tdata,
    // span_valid[0]
    output logic [psf_pkg::M_TUSER_W-1:0]         m_tuser,
    output logic                                  m_tlast,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [psf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [psf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import psf_pkg::*;

    localparam int VI_W   = $clog2(MAX_VERTICES);
    localparam int NV_W   = $clog2(MAX_VERTICES + 1);
    localparam int M_W    = ((COORD_BITS > 13) ? COORD_BITS : 13) + 2;
    localparam int NUM_W  = 2 * M_W + 1;
    localparam int X_W    = COORD_BITS + 1;
    localparam int DC_W   = $clog2(NUM_W + 1);
    localparam int CMP_W  = ((X_W > 14) ? X_W : 14) + 1;
    localparam int RES_W  = $clog2(MAX_RESULTS + 1);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_PREV = 10'b0000000010,
        ST_EDGE = 10'b0000000100,
        ST_MUL1 = 10'b0000001000,
        ST_MUL2 = 10'b0000010000,
        ST_DSET = 10'b0000100000,
        ST_DIV  = 10'b0001000000,
        ST_INS  = 10'b0010000000,
        ST_PAIR = 10'b0100000000,
        ST_FIN  = 10'b1000000000
    } state_t;

    state_t state_reg;

    logic [WIDTH_W-1:0]  scan_width_reg;
    logic [VCOUNT_W-1:0] vertex_count_reg;

    logic signed [COORD_BITS-1:0] vx_mem [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] vy_mem [MAX_VERTICES];

    logic [NV_W-1:0]              i_reg, nv_reg;
    logic [SCAN_Y_W-1:0]          py_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg, cur_x_reg, cur_y_reg;
    logic signed [M_W-1:0]        den_reg, dy_reg, dx_reg;
    logic signed [2*M_W-1:0]      prod_reg;
    logic signed [NUM_W-1:0]      num_reg;
    logic [NUM_W-1:0]             q_reg;
    logic [M_W:0]                 rem_reg;
    logic [M_W-1:0]               dmag_reg;
    logic                         qneg_reg;
    logic [DC_W-1:0]              dcnt_reg;

    logic signed [X_W-1:0] list_reg [MAX_VERTICES];
    logic [NV_W-1:0]       lcnt_reg;

    logic              pend_valid_reg;
    logic [SPAN_W-1:0] pend_start_reg, pend_end_reg;
    logic [RES_W-1:0]  nres_reg;

    logic                 m_tvalid_reg, m_tlast_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    // Input fields.
    logic                          in_kind;
    logic [INDEX_W-1:0]            in_index;
    logic signed [IN_COORD_W-1:0]  in_x, in_y;
    logic [SCAN_Y_W-1:0]           in_scan_y;
    logic signed [31:0]            in_x_ext, in_y_ext;

    assign in_kind   = s_tuser[0];
    assign in_index  = s_tdata[3:0];
    assign in_x      = s_tdata[16:4];
    assign in_y      = s_tdata[29:17];
    assign in_scan_y = s_tdata[41:30];
    assign in_x_ext  = 32'(in_x);
    assign in_y_ext  = 32'(in_y);

    logic [NV_W-1:0] nv_clamped;
    assign nv_clamped = (int'(vertex_count_reg) > MAX_VERTICES) ?
                        NV_W'(MAX_VERTICES) : NV_W'(vertex_count_reg);

    // Single read port of the vertex store.
    logic [VI_W-1:0]              rd_idx;
    logic signed [COORD_BITS-1:0] rd_x, rd_y;
    assign rd_idx = (state_reg == ST_PREV) ? VI_W'(nv_reg - NV_W'(1)) : VI_W'(i_reg);
    assign rd_x   = vx_mem[rd_idx];
    assign rd_y   = vy_mem[rd_idx];

    // Edge test against the scanline.
    logic signed [M_W-1:0] py_ext, yi_ext, yj_ext, xi_ext, xj_ext;
    logic                  is_cross;
    assign py_ext   = M_W'(signed'({1'b0, py_reg}));
    assign yi_ext   = M_W'(rd_y);
    assign yj_ext   = M_W'(prev_y_reg);
    assign xi_ext   = M_W'(rd_x);
    assign xj_ext   = M_W'(prev_x_reg);
    assign is_cross = ((yi_ext < py_ext) && (yj_ext >= py_ext)) ||
                      ((yj_ext < py_ext) && (yi_ext >= py_ext));

    // Shared multiplier: xi*den first, then (py-yi)*(xj-xi).
    logic signed [M_W-1:0]   mul_a, mul_b;
    logic signed [2*M_W-1:0] mul_p;
    assign mul_a = (state_reg == ST_MUL1) ? M_W'(cur_x_reg) : dy_reg;
    assign mul_b = (state_reg == ST_MUL1) ? den_reg : dx_reg;
    assign mul_p = mul_a * mul_b;

    // Restoring divider step on magnitudes.
    logic [M_W:0] rem_sh;
    logic         rem_ge;
    assign rem_sh = {rem_reg[M_W-1:0], q_reg[NUM_W-1]};
    assign rem_ge = rem_sh >= {1'b0, dmag_reg};

    logic signed [X_W-1:0] quo;
    assign quo = qneg_reg ? -signed'(q_reg[X_W-1:0]) : signed'(q_reg[X_W-1:0]);

    // Insertion of a new crossing into the sorted list, one cell per slot.
    logic signed [X_W-1:0] ins_list [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] gt;
    always_comb begin
        for (int k = 0; k < MAX_VERTICES; k++) begin
            gt[k] = (NV_W'(k) >= lcnt_reg) || (list_reg[k] > quo);
        end
        ins_list[0] = gt[0] ? quo : list_reg[0];
        for (int k = 1; k < MAX_VERTICES; k++) begin
            if (!gt[k]) begin
                ins_list[k] = list_reg[k];
            end else if (!gt[k-1]) begin
                ins_list[k] = quo;
            end else begin
                ins_list[k] = list_reg[k-1];
            end
        end
    end

    // The list drops its first pair after each pairing step.
    logic signed [X_W-1:0] sh_list [MAX_VERTICES];
    always_comb begin
        for (int k = 0; k < MAX_VERTICES; k++) begin
            sh_list[k] = (k + 2 < MAX_VERTICES) ? list_reg[(k + 2) % MAX_VERTICES]
                                                : list_reg[k];
        end
    end

    // Pair evaluation on the two lowest crossings.
    logic [WIDTH_W-1:0]      wmin, wm1;
    logic signed [CMP_W-1:0] s_c, e_c, w_c;
    logic                    s_ge_w, e_pos, e_ge_w, pair_stop;
    logic [SPAN_W-1:0]       s_clamp, e_clamp;
    assign wmin      = (int'(scan_width_reg) > WIDTH_LIMIT) ? WIDTH_W'(WIDTH_LIMIT)
                                                            : scan_width_reg;
    assign wm1       = wmin - WIDTH_W'(1);
    assign s_c       = CMP_W'(list_reg[0]);
    assign e_c       = CMP_W'(list_reg[1]);
    assign w_c       = CMP_W'(signed'({1'b0, wmin}));
    assign s_ge_w    = s_c >= w_c;
    assign e_ge_w    = e_c >= w_c;
    assign e_pos     = !e_c[CMP_W-1] && (e_c != '0);
    assign s_clamp   = s_c[CMP_W-1] ? '0 : s_c[SPAN_W-1:0];
    assign e_clamp   = e_ge_w ? wm1[SPAN_W-1:0] : e_c[SPAN_W-1:0];
    assign pair_stop = (lcnt_reg < NV_W'(2)) || s_ge_w ||
                       (nres_reg == RES_W'(MAX_RESULTS));

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    // The output register takes a new result in this cycle.
    logic out_load;
    assign out_load = out_free &&
                      (((state_reg == ST_PAIR) && !pair_stop && e_pos && pend_valid_reg) ||
                       (state_reg == ST_FIN));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            scan_width_reg   <= SCAN_WIDTH_RESET;
            vertex_count_reg <= VERTEX_COUNT_RESET;
            m_tvalid_reg     <= 1'b0;
            pend_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SCAN_WIDTH:   scan_width_reg   <= cfg_data;
                    REG_VERTEX_COUNT: vertex_count_reg <= cfg_data[VCOUNT_W-1:0];
                    default: ;
                endcase
            end

            if (m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (in_kind == KIND_LOAD) begin
                            if (int'(in_index) < MAX_VERTICES) begin
                                vx_mem[VI_W'(in_index)] <= in_x_ext[COORD_BITS-1:0];
                                vy_mem[VI_W'(in_index)] <= in_y_ext[COORD_BITS-1:0];
                            end
                        end else begin
                            py_reg         <= in_scan_y;
                            nv_reg         <= nv_clamped;
                            lcnt_reg       <= '0;
                            nres_reg       <= '0;
                            pend_valid_reg <= 1'b0;
                            state_reg      <= (nv_clamped == '0) ? ST_PAIR : ST_PREV;
                        end
                    end
                end
                ST_PREV: begin
                    prev_x_reg <= rd_x;
                    prev_y_reg <= rd_y;
                    i_reg      <= '0;
                    state_reg  <= ST_EDGE;
                end
                ST_EDGE: begin
                    cur_x_reg <= rd_x;
                    cur_y_reg <= rd_y;
                    if (is_cross) begin
                        den_reg   <= yj_ext - yi_ext;
                        dy_reg    <= py_ext - yi_ext;
                        dx_reg    <= xj_ext - xi_ext;
                        state_reg <= ST_MUL1;
                    end else begin
                        prev_x_reg <= rd_x;
                        prev_y_reg <= rd_y;
                        i_reg      <= i_reg + NV_W'(1);
                        if (i_reg + NV_W'(1) == nv_reg) begin
                            state_reg <= ST_PAIR;
                        end
                    end
                end
                ST_MUL1: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    num_reg   <= NUM_W'(prod_reg) + NUM_W'(mul_p);
                    state_reg <= ST_DSET;
                end
                ST_DSET: begin
                    q_reg     <= num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
                    dmag_reg  <= den_reg[M_W-1] ? M_W'(-den_reg) : M_W'(den_reg);
                    qneg_reg  <= num_reg[NUM_W-1] ^ den_reg[M_W-1];
                    rem_reg   <= '0;
                    dcnt_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg  <= rem_ge ? rem_sh - {1'b0, dmag_reg} : rem_sh;
                    q_reg    <= {q_reg[NUM_W-2:0], rem_ge};
                    dcnt_reg <= dcnt_reg + DC_W'(1);
                    if (dcnt_reg == DC_W'(NUM_W - 1)) begin
                        state_reg <= ST_INS;
                    end
                end
                ST_INS: begin
                    for (int k = 0; k < MAX_VERTICES; k++) begin
                        list_reg[k] <= ins_list[k];
                    end
                    lcnt_reg   <= lcnt_reg + NV_W'(1);
                    prev_x_reg <= cur_x_reg;
                    prev_y_reg <= cur_y_reg;
                    i_reg      <= i_reg + NV_W'(1);
                    state_reg  <= (i_reg + NV_W'(1) == nv_reg) ? ST_PAIR : ST_EDGE;
                end
                ST_PAIR: begin
                    if (out_free) begin
                        if (pair_stop) begin
                            state_reg <= ST_FIN;
                        end else begin
                            for (int k = 0; k < MAX_VERTICES; k++) begin
                                list_reg[k] <= sh_list[k];
                            end
                            lcnt_reg <= lcnt_reg - NV_W'(2);
                            if (e_pos) begin
                                // A held span is sent once it is known not to be the last.
                                if (pend_valid_reg) begin
                                    m_tvalid_reg <= 1'b1;
                                    m_tdata_reg  <= {pend_end_reg, pend_start_reg};
                                    m_tuser_reg  <= 1'b1;
                                    m_tlast_reg  <= 1'b0;
                                end
                                pend_valid_reg <= 1'b1;
                                pend_start_reg <= s_clamp;
                                pend_end_reg   <= e_clamp;
                                nres_reg       <= nres_reg + RES_W'(1);
                            end
                        end
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_tvalid_reg   <= 1'b1;
                        m_tlast_reg    <= 1'b1;
                        m_tuser_reg    <= pend_valid_reg;
                        m_tdata_reg    <= pend_valid_reg ? {pend_end_reg, pend_start_reg}
                                                         : '0;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;

endmodule

`default_nettype wire

// ----- rtl/psf_checker.sv -----
// Port-level checker for the span fill unit and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "polygon_scanline_span_fill_unit_macros.svh"

module psf_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic [psf_pkg::S_TUSER_W-1:0]    s_tuser,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [psf_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic [psf_pkg::M_TUSER_W-1:0]    m_tuser,
    input wire logic                             m_tlast
);
    import psf_pkg::*;

    logic query_acc, load_acc;
    assign query_acc = s_tvalid && s_tready && (s_tuser[0] == KIND_QUERY);
    assign load_acc  = s_tvalid && s_tready && (s_tuser[0] == KIND_LOAD);

    `PSF_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "stalled result changed")
    `PSF_ASSERT_NXT(a_query_busy, aclk, aresetn, query_acc, !s_tready,
        "ready right after a query request")
    `PSF_ASSERT_NXT(a_load_quick, aclk, aresetn, load_acc, s_tready,
        "vertex load held the input")
    `PSF_ASSERT_IMP(a_nospan_last, aclk, aresetn, m_tvalid && !m_tuser[0], m_tlast,
        "no-span result not marked last")
    `PSF_ASSERT_IMP(a_span_order, aclk, aresetn, m_tvalid && m_tuser[0],
        m_tdata[11:0] <= m_tdata[23:12], "span start after span end")

endmodule

bind polygon_scanline_span_fill_unit psf_checker u_psf_checker (.*);

`default_nettype wire

// ----- tb/sv/span_fill_checker.sv -----
// Checker for the span fill unit: predicts spans per scanline and compares results.
`timescale 1ns / 1ps
`default_nettype none

module span_fill_checker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic [psf_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [psf_pkg::S_TUSER_W-1:0]    s_tuser,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [psf_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire logic [psf_pkg::M_TUSER_W-1:0]    m_tuser,
    input  wire logic                             m_tlast,
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [psf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [psf_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                    fail_count,
    output int                                    spans_pending
);
    import psf_pkg::*;

    typedef struct packed {
        logic              present;
        logic [SPAN_W-1:0] first_col;
        logic [SPAN_W-1:0] end_col;
        logic              final_one;
    } span_t;

    span_t span_queue[$];
    logic signed [IN_COORD_W-1:0] corner_x[MAX_VERTICES_DEF];
    logic signed [IN_COORD_W-1:0] corner_y[MAX_VERTICES_DEF];
    logic [WIDTH_W-1:0]  canvas_width;
    logic [VCOUNT_W-1:0] corner_count;

    initial fail_count = 0;
    assign spans_pending = span_queue.size();

    task automatic report(input string what);
        $display("%t: span check failed: %s", $realtime, what);
        fail_count++;
    endtask

    // Builds the expected spans of one scanline, in order, into the queue.
    task automatic predict_spans(input logic [SCAN_Y_W-1:0] row);
        longint xs[MAX_VERTICES_DEF];
        longint py, w, yi, yj, xi, xj, den, num, v, s, e;
        int nx, nv, j, k, produced;
        span_t sp;
        nx = 0;
        produced = 0;
        py = row;
        w = (canvas_width > WIDTH_LIMIT) ? WIDTH_LIMIT : canvas_width;
        nv = (corner_count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : corner_count;
        j = nv - 1;
        for (int i = 0; i < nv; i++) begin
            yi = corner_y[i];
            yj = corner_y[j];
            if ((yi < py && yj >= py) || (yj < py && yi >= py)) begin
                xi = corner_x[i];
                xj = corner_x[j];
                den = yj - yi;
                num = xi * den + (py - yi) * (xj - xi);
                xs[nx] = num / den;
                nx++;
            end
            j = i;
        end
        for (int i = 1; i < nx; i++) begin
            v = xs[i];
            k = i - 1;
            while (k >= 0 && xs[k] > v) begin
                xs[k + 1] = xs[k];
                k--;
            end
            xs[k + 1] = v;
        end
        for (int i = 0; i + 1 < nx && produced < MAX_RESULTS; i += 2) begin
            s = xs[i];
            e = xs[i + 1];
            if (s >= w) break;
            if (e > 0) begin
                if (s < 0) s = 0;
                if (e >= w) e = w - 1;
                sp.present = 1'b1;
                sp.first_col = s[SPAN_W-1:0];
                sp.end_col = e[SPAN_W-1:0];
                sp.final_one = 1'b0;
                span_queue.push_back(sp);
                produced++;
            end
        end
        if (produced == 0) begin
            sp = '0;
            sp.final_one = 1'b1;
            span_queue.push_back(sp);
        end else begin
            span_queue[span_queue.size() - 1].final_one = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        span_t got, want;
        if (!aresetn) begin
            canvas_width <= SCAN_WIDTH_RESET;
            corner_count <= VERTEX_COUNT_RESET;
            span_queue.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_SCAN_WIDTH) canvas_width <= cfg_data;
                else if (cfg_index == REG_VERTEX_COUNT) corner_count <= cfg_data[VCOUNT_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == KIND_LOAD) begin
                    corner_x[s_tdata[3:0]] = s_tdata[16:4];
                    corner_y[s_tdata[3:0]] = s_tdata[29:17];
                end else begin
                    predict_spans(s_tdata[41:30]);
                end
            end
            if (m_tvalid && m_tready) begin
                got.present = m_tuser[0];
                got.first_col = m_tdata[11:0];
                got.end_col = m_tdata[23:12];
                got.final_one = m_tlast;
                if (span_queue.size() == 0) begin
                    report($sformatf("unexpected span %0d..%0d", got.first_col, got.end_col));
                end else begin
                    want = span_queue.pop_front();
                    if (got.present !== want.present)
                        report($sformatf("span_valid %b, want %b", got.present, want.present));
                    if (got.first_col !== want.first_col)
                        report($sformatf("span_start %0d, want %0d", got.first_col,
                                         want.first_col));
                    if (got.end_col !== want.end_col)
                        report($sformatf("span_end %0d, want %0d", got.end_col, want.end_col));
                    if (got.final_one !== want.final_one)
                        report($sformatf("last %b, want %b", got.final_one, want.final_one));
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Top of the span fill testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import psf_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int fail_count, spans_pending;
    bit steady = 1'b0;
    int drain_wait = 0;

    polygon_scanline_span_fill_unit DUT (.*);
    span_fill_checker checker_i (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver stall: after each accepted result, wait a drawn number of cycles (none while steady).
    always @(posedge aclk) begin
        int w;
        if (!aresetn) begin
            m_tready <= 1'b0;
            drain_wait <= 0;
        end else if (m_tvalid && m_tready) begin
            w = steady ? 0 : $urandom_range(8);
            if (w != 0) begin
                m_tready <= 1'b0;
                drain_wait <= w;
            end
        end else if (!m_tready) begin
            if (drain_wait <= 1) m_tready <= 1'b1;
            drain_wait <= drain_wait - 1;
        end
    end

    task automatic send_request(input logic kind, input logic [3:0] idx,
                                input logic [12:0] x, input logic [12:0] y,
                                input logic [11:0] row);
        int gap;
        gap = steady ? 0 : $urandom_range(8);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {6'b0, row, y, x, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Lets every expected span drain, then covers a load still in flight.
    // The first edge lets the checker record the request accepted just before.
    task automatic settle();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (spans_pending != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (60) @(posedge aclk);
    endtask

    function automatic logic [12:0] pick_coord(input int hi);
        if ($urandom_range(9) == 0) return 13'($urandom);
        return 13'($urandom_range(hi + 64) - 64);
    endfunction

    initial begin
        int widths[9] = '{4096, 1, 200, 8191, 0, 640, 37, 4096, 13};
        int counts[9] = '{16, 3, 4, 31, 2, 8, 1, 16, 0};
        int nload, span_x, span_y;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Comb polygon of sixteen vertices across the full coordinate range.
        write_reg(REG_SCAN_WIDTH, 13'd4096);
        write_reg(REG_VERTEX_COUNT, 5'd16);
        for (int k = 0; k < 16; k++)
            send_request(KIND_LOAD, 4'(k), (k == 15) ? 13'sd4095 : 13'(-4096 + k * 546),
                         k[0] ? 13'sd4095 : -13'sd4096, '0);
        send_request(KIND_QUERY, '0, '0, '0, 12'd0);
        send_request(KIND_QUERY, '0, '0, '0, 12'd4095);
        send_request(KIND_QUERY, '0, '0, '0, 12'd2000);
        send_request(KIND_QUERY, '0, '0, '0, 12'd1);
        settle();

        for (int p = 0; p < 9; p++) begin
            write_reg(REG_SCAN_WIDTH, 13'(widths[p]));
            write_reg(REG_VERTEX_COUNT, 5'(counts[p]));
            steady = p[0];
            span_x = (widths[p] > 600) ? 600 : widths[p] + 8;
            span_y = $urandom_range(1) ? 300 : 4095;
            nload = $urandom_range(16, 6);
            for (int k = 0; k < nload; k++)
                send_request(KIND_LOAD, ($urandom_range(7) == 0) ? 4'($urandom) : 4'(k),
                             pick_coord(span_x), pick_coord(span_y), '0);
            for (int q = 0; q < 22; q++)
                send_request(KIND_QUERY, 4'($urandom), 13'($urandom), 13'($urandom),
                             ($urandom_range(5) == 0) ? 12'($urandom)
                                                      : 12'($urandom_range(span_y)));
            settle();
        end

        repeat (100) @(posedge aclk);
        if (fail_count == 0 && spans_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
